FILE: rtl/core/cidma_pkg.sv
package cidma_pkg;

    // default sizes, handed to the top level parameters
    localparam int LOCAL_WORDS_DEF    = 512;
    localparam int SIGNAL_COUNT_DEF   = 8;
    localparam int MAIN_ADDR_BITS_DEF = 21;

    // item operations
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BREAK = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // register map
    localparam logic [3:0] REG_LOCAL_ADDR = 4'd0;
    localparam logic [3:0] REG_MAIN_ADDR  = 4'd1;
    localparam logic [3:0] REG_TO_LOCAL   = 4'd2;
    localparam logic [3:0] REG_TO_MAIN    = 4'd3;
    localparam logic [3:0] REG_STATUS     = 4'd4;
    localparam logic [3:0] REG_DMA_FULL   = 4'd5;
    localparam logic [3:0] REG_DMA_BUSY   = 4'd6;
    localparam logic [3:0] REG_SEMAPHORE  = 4'd7;
    localparam logic [3:0] REG_PC         = 4'd8;

    // set/clear pair codes in the status write word
    localparam logic [1:0] PAIR_CLEAR = 2'b01;
    localparam logic [1:0] PAIR_SET   = 2'b10;

    // row length field reported once a transfer is done
    localparam logic [8:0] LEN_DONE_BEATS = 9'h1FF;

    // one bus/tick item
    typedef struct packed {
        op_t         op;
        logic [3:0]  idx;
        logic [31:0] data;
    } item_t;

    // length register: only the bits kept by the write mask
    typedef struct packed {
        logic [8:0] skip;   // bits 31:23
        logic [7:0] rows;   // bits 19:12
        logic [8:0] beats;  // bits 11:3
    } len_t;

    // one result item
    typedef struct packed {
        logic [31:0] read_data;
        logic        beat_valid;
        logic        beat_to_main;
        logic        beat_instr_mem;
        logic [8:0]  beat_local_index;
        logic [20:0] beat_main_word;
        logic        beat_last;
        logic        irq_raise;
        logic        irq_clear;
        logic        pc_write_valid;
        logic [31:0] pc_value;
        logic        halted;
    } result_t;

    function automatic len_t len_from_word(input logic [31:0] w);
        len_t l;
        l.skip  = w[31:23];
        l.rows  = w[19:12];
        l.beats = w[11:3];
        return l;
    endfunction

    function automatic logic [31:0] len_to_word(input len_t l);
        return {l.skip, 3'b000, l.rows, l.beats, 3'b000};
    endfunction

    // set/clear pair: both or neither leaves the bit alone
    function automatic logic pair_update(input logic cur, input logic [1:0] sel);
        logic r;
        unique case (sel)
            PAIR_CLEAR: r = 1'b0;
            PAIR_SET:   r = 1'b1;
            default:    r = cur;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/cidma_in_stage.sv
module cidma_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cidma_pkg::item_t  s_item,
    output logic              item_valid,
    output cidma_pkg::item_t  item,
    input  logic              item_take
);

    logic             valid_reg;
    logic             valid_next;
    cidma_pkg::item_t item_reg;

    // room when empty or when the held beat leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/core/cidma_engine.sv
module cidma_engine #(
    parameter int LOCAL_WORDS    = cidma_pkg::LOCAL_WORDS_DEF,
    parameter int SIGNAL_COUNT   = cidma_pkg::SIGNAL_COUNT_DEF,
    parameter int MAIN_ADDR_BITS = cidma_pkg::MAIN_ADDR_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  cidma_pkg::item_t    item,
    output logic                item_take,
    input  logic                res_ready,
    output logic                res_valid,
    output cidma_pkg::result_t  res
);

    localparam int LW = $clog2(LOCAL_WORDS);
    localparam int MA = MAIN_ADDR_BITS;
    localparam int SC = SIGNAL_COUNT;

    // architectural state
    logic [LW-1:0]   local_addr_reg,    local_addr_next;
    logic            local_instr_reg,   local_instr_next;
    logic [MA-1:0]   main_addr_reg,     main_addr_next;
    cidma_pkg::len_t to_local_len_reg,  to_local_len_next;
    cidma_pkg::len_t to_main_len_reg,   to_main_len_next;
    logic            halted_reg,        halted_next;
    logic            broke_reg,         broke_next;
    logic            single_step_reg,   single_step_next;
    logic            irq_on_break_reg,  irq_on_break_next;
    logic [SC-1:0]   signal_reg,        signal_next;
    logic            semaphore_reg,     semaphore_next;
    logic            dma_active_reg,    dma_active_next;
    logic            dma_to_main_reg,   dma_to_main_next;
    logic [8:0]      beats_left_reg,    beats_left_next;
    logic [7:0]      rows_left_reg,     rows_left_next;
    logic [8:0]      row_reload_reg,    row_reload_next;
    logic [8:0]      row_skip_reg,      row_skip_next;

    logic            fire;
    logic [LW-1:0]   local_inc;
    logic [MA-1:0]   main_inc;
    logic [MA-1:0]   main_skip;
    logic [31:0]     local_wide;
    logic [31:0]     main_wide;
    logic [31:0]     status_word;
    logic [1:0]      sig_sel;
    logic [1:0]      irq_sel;
    cidma_pkg::len_t len_wr;

    assign fire      = item_valid && res_ready;
    assign item_take = fire;
    assign res_valid = fire;

    // address steps of one beat
    assign local_inc  = local_addr_reg + 1'b1;
    assign main_inc   = main_addr_reg + 1'b1;
    assign main_skip  = main_inc + MA'(row_skip_reg);
    assign local_wide = 32'(local_addr_reg);
    assign main_wide  = 32'(main_addr_reg);
    assign len_wr     = cidma_pkg::len_from_word(item.data);
    assign irq_sel    = item.data[4:3];

    assign status_word = 32'(halted_reg)
                       | (32'(broke_reg) << 1)
                       | (32'(dma_active_reg) << 2)
                       | (32'(single_step_reg) << 5)
                       | (32'(irq_on_break_reg) << 6)
                       | (32'(signal_reg) << 7);

    // next state and result
    always_comb begin
        local_addr_next   = local_addr_reg;
        local_instr_next  = local_instr_reg;
        main_addr_next    = main_addr_reg;
        to_local_len_next = to_local_len_reg;
        to_main_len_next  = to_main_len_reg;
        halted_next       = halted_reg;
        broke_next        = broke_reg;
        single_step_next  = single_step_reg;
        irq_on_break_next = irq_on_break_reg;
        signal_next       = signal_reg;
        semaphore_next    = semaphore_reg;
        dma_active_next   = dma_active_reg;
        dma_to_main_next  = dma_to_main_reg;
        beats_left_next   = beats_left_reg;
        rows_left_next    = rows_left_reg;
        row_reload_next   = row_reload_reg;
        row_skip_next     = row_skip_reg;
        sig_sel           = 2'b00;
        res               = '0;

        if (fire) begin
            unique case (item.op)
                cidma_pkg::OP_READ: begin
                    unique case (item.idx)
                        cidma_pkg::REG_LOCAL_ADDR:
                            res.read_data = (local_wide << 3) | (32'(local_instr_reg) << 12);
                        cidma_pkg::REG_MAIN_ADDR:
                            res.read_data = main_wide << 3;
                        cidma_pkg::REG_TO_LOCAL:
                            res.read_data = cidma_pkg::len_to_word(to_local_len_reg);
                        cidma_pkg::REG_TO_MAIN:
                            res.read_data = cidma_pkg::len_to_word(to_main_len_reg);
                        cidma_pkg::REG_STATUS:
                            res.read_data = status_word;
                        cidma_pkg::REG_DMA_BUSY:
                            res.read_data = 32'(dma_active_reg);
                        cidma_pkg::REG_SEMAPHORE: begin
                            res.read_data  = 32'(semaphore_reg);
                            semaphore_next = 1'b1;
                        end
                        default: res.read_data = '0;
                    endcase
                end

                cidma_pkg::OP_WRITE: begin
                    unique case (item.idx)
                        cidma_pkg::REG_LOCAL_ADDR: begin
                            local_addr_next  = LW'(32'(item.data[11:3]));
                            local_instr_next = item.data[12];
                        end
                        cidma_pkg::REG_MAIN_ADDR:
                            main_addr_next = item.data[MA+2:3];
                        cidma_pkg::REG_TO_LOCAL, cidma_pkg::REG_TO_MAIN: begin
                            // length writes start a transfer, ignored while busy
                            if (!dma_active_reg) begin
                                if (item.idx == cidma_pkg::REG_TO_MAIN) begin
                                    to_main_len_next = len_wr;
                                    dma_to_main_next = 1'b1;
                                end else begin
                                    to_local_len_next = len_wr;
                                    dma_to_main_next  = 1'b0;
                                end
                                dma_active_next = 1'b1;
                                beats_left_next = len_wr.beats;
                                row_reload_next = len_wr.beats;
                                rows_left_next  = len_wr.rows;
                                row_skip_next   = len_wr.skip;
                            end
                        end
                        cidma_pkg::REG_STATUS: begin
                            halted_next = cidma_pkg::pair_update(halted_reg, item.data[1:0]);
                            if (item.data[2]) begin
                                broke_next = 1'b0;
                            end
                            res.irq_clear = (irq_sel == cidma_pkg::PAIR_CLEAR);
                            res.irq_raise = (irq_sel == cidma_pkg::PAIR_SET);
                            single_step_next =
                                cidma_pkg::pair_update(single_step_reg, item.data[6:5]);
                            irq_on_break_next =
                                cidma_pkg::pair_update(irq_on_break_reg, item.data[8:7]);
                            for (int s = 0; s < SC; s++) begin
                                sig_sel        = item.data[9 + 2*s +: 2];
                                signal_next[s] = cidma_pkg::pair_update(signal_reg[s], sig_sel);
                            end
                        end
                        cidma_pkg::REG_SEMAPHORE:
                            semaphore_next = item.data[0];
                        cidma_pkg::REG_PC: begin
                            res.pc_write_valid = 1'b1;
                            res.pc_value       = item.data;
                        end
                        default: ;
                    endcase
                end

                cidma_pkg::OP_BREAK: begin
                    halted_next   = 1'b1;
                    broke_next    = 1'b1;
                    res.irq_raise = irq_on_break_reg;
                end

                cidma_pkg::OP_TICK: begin
                    // one beat per tick while a transfer runs
                    if (dma_active_reg) begin
                        res.beat_valid       = 1'b1;
                        res.beat_to_main     = dma_to_main_reg;
                        res.beat_instr_mem   = local_instr_reg;
                        res.beat_local_index = local_wide[8:0];
                        res.beat_main_word   = main_wide[20:0];
                        local_addr_next      = local_inc;
                        main_addr_next       = main_inc;
                        if (beats_left_reg == '0) begin
                            if (rows_left_reg == '0) begin
                                // end of transfer
                                res.beat_last   = 1'b1;
                                dma_active_next = 1'b0;
                                if (dma_to_main_reg) begin
                                    to_main_len_next.rows  = '0;
                                    to_main_len_next.beats = cidma_pkg::LEN_DONE_BEATS;
                                end else begin
                                    to_local_len_next.rows  = '0;
                                    to_local_len_next.beats = cidma_pkg::LEN_DONE_BEATS;
                                end
                            end else begin
                                // next row, skip over the gap in main memory
                                rows_left_next  = rows_left_reg - 1'b1;
                                beats_left_next = row_reload_reg;
                                main_addr_next  = main_skip;
                            end
                        end else begin
                            beats_left_next = beats_left_reg - 1'b1;
                        end
                    end
                end

                default: ;
            endcase
            res.halted = halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg   <= '0;
            local_instr_reg  <= 1'b0;
            main_addr_reg    <= '0;
            to_local_len_reg <= '0;
            to_main_len_reg  <= '0;
            halted_reg       <= 1'b1;
            broke_reg        <= 1'b0;
            single_step_reg  <= 1'b0;
            irq_on_break_reg <= 1'b0;
            signal_reg       <= '0;
            semaphore_reg    <= 1'b0;
            dma_active_reg   <= 1'b0;
            dma_to_main_reg  <= 1'b0;
            beats_left_reg   <= '0;
            rows_left_reg    <= '0;
            row_reload_reg   <= '0;
            row_skip_reg     <= '0;
        end else begin
            local_addr_reg   <= local_addr_next;
            local_instr_reg  <= local_instr_next;
            main_addr_reg    <= main_addr_next;
            to_local_len_reg <= to_local_len_next;
            to_main_len_reg  <= to_main_len_next;
            halted_reg       <= halted_next;
            broke_reg        <= broke_next;
            single_step_reg  <= single_step_next;
            irq_on_break_reg <= irq_on_break_next;
            signal_reg       <= signal_next;
            semaphore_reg    <= semaphore_next;
            dma_active_reg   <= dma_active_next;
            dma_to_main_reg  <= dma_to_main_next;
            beats_left_reg   <= beats_left_next;
            rows_left_reg    <= rows_left_next;
            row_reload_reg   <= row_reload_next;
            row_skip_reg     <= row_skip_next;
        end
    end

endmodule

FILE: rtl/core/cidma_out_stage.sv
module cidma_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    output logic                res_ready,
    input  cidma_pkg::result_t  res,
    output logic                m_valid,
    input  logic                m_ready,
    output cidma_pkg::result_t  m_res
);

    logic               valid_reg;
    logic               valid_next;
    cidma_pkg::result_t res_reg;

    // a new result may enter when empty or when the held one is taken
    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = res_valid || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

FILE: rtl/core/coprocessor_interface_strided_dma_core.sv
// Register front of a coprocessor interface with a strided DMA engine.
// Input channel (s_valid/s_ready): one beat per bus read, bus write, break
// event or DMA tick, selected by s_operation; s_reg_index picks one of the
// nine registers, s_write_data carries write data.
// Result channel (m_valid/m_ready): exactly one beat per input beat, in
// order, with the read value, the DMA beat issued by a tick, interrupt
// pulses, a forwarded PC write and the halted flag after the item.
// Path: an input beat once accepted sits in the input register; its result
// is computed from it and registered in the result register, where m_valid
// rises and the receiver can take it.
// Throughput: one item per cycle while m_ready is high; all per-item work
// is a single pass of logic between the input and result registers.
// Stalls: when m_ready is low the result register holds and the input
// register can still take one more beat; s_ready falls only when both
// are full.
// Reset (aresetn low, synchronous): both stages empty, the block halted,
// no transfer running, all other address, length and flag registers zero.
module coprocessor_interface_strided_dma_core #(
    parameter int LOCAL_WORDS    = cidma_pkg::LOCAL_WORDS_DEF,
    parameter int SIGNAL_COUNT   = cidma_pkg::SIGNAL_COUNT_DEF,
    parameter int MAIN_ADDR_BITS = cidma_pkg::MAIN_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_reg_index,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_beat_valid,
    output logic        m_beat_to_main,
    output logic        m_beat_instr_mem,
    output logic [8:0]  m_beat_local_index,
    output logic [20:0] m_beat_main_word,
    output logic        m_beat_last,
    output logic        m_irq_raise,
    output logic        m_irq_clear,
    output logic        m_pc_write_valid,
    output logic [31:0] m_pc_value,
    output logic        m_halted
);

    cidma_pkg::item_t   s_item;
    cidma_pkg::item_t   item;
    logic               item_valid;
    logic               item_take;
    cidma_pkg::result_t res;
    logic               res_valid;
    logic               res_ready;
    cidma_pkg::result_t m_res;

    assign s_item.op   = cidma_pkg::op_t'(s_operation);
    assign s_item.idx  = s_reg_index;
    assign s_item.data = s_write_data;

    cidma_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    cidma_engine #(
        .LOCAL_WORDS    (LOCAL_WORDS),
        .SIGNAL_COUNT   (SIGNAL_COUNT),
        .MAIN_ADDR_BITS (MAIN_ADDR_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    cidma_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    // result fields to ports
    assign m_read_data        = m_res.read_data;
    assign m_beat_valid       = m_res.beat_valid;
    assign m_beat_to_main     = m_res.beat_to_main;
    assign m_beat_instr_mem   = m_res.beat_instr_mem;
    assign m_beat_local_index = m_res.beat_local_index;
    assign m_beat_main_word   = m_res.beat_main_word;
    assign m_beat_last        = m_res.beat_last;
    assign m_irq_raise        = m_res.irq_raise;
    assign m_irq_clear        = m_res.irq_clear;
    assign m_pc_write_valid   = m_res.pc_write_valid;
    assign m_pc_value         = m_res.pc_value;
    assign m_halted           = m_res.halted;

endmodule

FILE: rtl/core/cidma_checker.sv
module cidma_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_beat_valid,
    input logic        m_beat_to_main,
    input logic        m_beat_instr_mem,
    input logic [8:0]  m_beat_local_index,
    input logic [20:0] m_beat_main_word,
    input logic        m_beat_last,
    input logic        m_irq_raise,
    input logic        m_irq_clear,
    input logic        m_pc_write_valid,
    input logic [31:0] m_pc_value
);

    // reset empties the result stage
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result keeps its read value under stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result changed");

    // beat fields are zero unless a beat is issued; last only with a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_beat_valid |->
            !m_beat_last && !m_beat_to_main && !m_beat_instr_mem &&
            m_beat_local_index == '0 && m_beat_main_word == '0)
        else $error("beat fields without a beat");

    // a read value excludes beats, pc writes and interrupt pulses
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_data != '0 |->
            !m_beat_valid && !m_pc_write_valid && !m_irq_raise && !m_irq_clear)
        else $error("read result mixed with other effects");

    // interrupt pulses never both, pc value only with a pc write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_irq_raise && m_irq_clear) &&
            (m_pc_write_valid || m_pc_value == '0))
        else $error("conflicting interrupt pulses or stray pc value");

endmodule

bind coprocessor_interface_strided_dma_core cidma_checker u_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import cidma_pkg::*;

    // bits kept by a length write, and the row fields rewritten at the end
    localparam logic [31:0] LEN_KEEP_MASK  = 32'hFF8F_FFF8;
    localparam logic [31:0] LEN_ROW_FIELDS = 32'h000F_FFF8;
    localparam int          ITEM_TARGET    = 950;
    localparam int          LONG_HOLD      = 64;

    // mirror of the register front plus the queue of pending results
    class dma_scoreboard;
        logic [8:0]  local_idx;
        logic        local_instr;
        logic [20:0] main_word;
        logic [31:0] len_to_local;
        logic [31:0] len_to_main;
        logic        halted;
        logic        broke;
        logic        single_step;
        logic        irq_on_break;
        logic [7:0]  signals;
        logic        sema;
        logic        dma_on;
        logic        dir_to_main;
        logic [8:0]  beats_left;
        logic [7:0]  rows_left;
        logic [9:0]  row_len;
        logic [8:0]  row_skip;
        result_t     expected_q[$];
        int          errors;
        int          n_results;
        int          n_beats;
        int          n_transfers;
        int          n_irq;

        function new();
            local_idx    = '0;
            local_instr  = 1'b0;
            main_word    = '0;
            len_to_local = '0;
            len_to_main  = '0;
            halted       = 1'b1;
            broke        = 1'b0;
            single_step  = 1'b0;
            irq_on_break = 1'b0;
            signals      = '0;
            sema         = 1'b0;
            dma_on       = 1'b0;
            dir_to_main  = 1'b0;
            beats_left   = '0;
            rows_left    = '0;
            row_len      = '0;
            row_skip     = '0;
            errors       = 0;
            n_results    = 0;
            n_beats      = 0;
            n_transfers  = 0;
            n_irq        = 0;
        endfunction

        function logic apply_set_clear(logic cur, logic [1:0] sel);
            if (sel == PAIR_CLEAR) return 1'b0;
            if (sel == PAIR_SET) return 1'b1;
            return cur;
        endfunction

        // work out the result of one accepted beat and advance the mirror
        function void note_item(op_t op, logic [3:0] idx, logic [31:0] data);
            result_t     exp;
            logic [31:0] lv;
            logic        last;
            exp = '0;
            last = 1'b0;
            case (op)
                OP_READ: begin
                    case (idx)
                        REG_LOCAL_ADDR: exp.read_data = {19'd0, local_instr, local_idx, 3'd0};
                        REG_MAIN_ADDR:  exp.read_data = {8'd0, main_word, 3'd0};
                        REG_TO_LOCAL:   exp.read_data = len_to_local;
                        REG_TO_MAIN:    exp.read_data = len_to_main;
                        REG_STATUS: begin
                            exp.read_data[0]    = halted;
                            exp.read_data[1]    = broke;
                            exp.read_data[2]    = dma_on;
                            exp.read_data[5]    = single_step;
                            exp.read_data[6]    = irq_on_break;
                            exp.read_data[14:7] = signals;
                        end
                        REG_DMA_BUSY: exp.read_data = {31'd0, dma_on};
                        REG_SEMAPHORE: begin
                            exp.read_data = {31'd0, sema};
                            sema = 1'b1;
                        end
                        default: exp.read_data = '0;
                    endcase
                end
                OP_WRITE: begin
                    case (idx)
                        REG_LOCAL_ADDR: begin
                            local_idx   = data[11:3];
                            local_instr = data[12];
                        end
                        REG_MAIN_ADDR: main_word = data[23:3];
                        REG_TO_LOCAL, REG_TO_MAIN: begin
                            // ignored while a transfer is running
                            if (!dma_on) begin
                                lv = data & LEN_KEEP_MASK;
                                if (idx == REG_TO_LOCAL) len_to_local = lv;
                                else len_to_main = lv;
                                dma_on      = 1'b1;
                                dir_to_main = (idx == REG_TO_MAIN);
                                beats_left  = lv[11:3];
                                row_len     = {1'b0, lv[11:3]} + 10'd1;
                                rows_left   = lv[19:12];
                                row_skip    = lv[31:23];
                            end
                        end
                        REG_STATUS: begin
                            halted = apply_set_clear(halted, data[1:0]);
                            if (data[2]) broke = 1'b0;
                            if (data[4:3] == PAIR_CLEAR) exp.irq_clear = 1'b1;
                            if (data[4:3] == PAIR_SET) exp.irq_raise = 1'b1;
                            single_step  = apply_set_clear(single_step, data[6:5]);
                            irq_on_break = apply_set_clear(irq_on_break, data[8:7]);
                            for (int s = 0; s < 8; s++)
                                signals[s] = apply_set_clear(signals[s], data[9 + 2 * s +: 2]);
                        end
                        REG_SEMAPHORE: sema = data[0];
                        REG_PC: begin
                            exp.pc_write_valid = 1'b1;
                            exp.pc_value       = data;
                        end
                        default: ;
                    endcase
                end
                OP_BREAK: begin
                    halted = 1'b1;
                    broke  = 1'b1;
                    if (irq_on_break) exp.irq_raise = 1'b1;
                end
                default: begin
                    // tick: one beat when a transfer is running
                    if (dma_on) begin
                        exp.beat_valid       = 1'b1;
                        exp.beat_to_main     = dir_to_main;
                        exp.beat_instr_mem   = local_instr;
                        exp.beat_local_index = local_idx;
                        exp.beat_main_word   = main_word;
                        local_idx = local_idx + 9'd1;
                        main_word = main_word + 21'd1;
                        if (beats_left == 0) begin
                            if (rows_left == 0) begin
                                last = 1'b1;
                            end else begin
                                rows_left  = rows_left - 8'd1;
                                beats_left = 9'(row_len - 10'd1);
                                main_word  = main_word + 21'(row_skip);
                            end
                        end else begin
                            beats_left = beats_left - 9'd1;
                        end
                        if (last) begin
                            if (dir_to_main)
                                len_to_main = (len_to_main & ~LEN_ROW_FIELDS)
                                              | {20'd0, LEN_DONE_BEATS, 3'd0};
                            else
                                len_to_local = (len_to_local & ~LEN_ROW_FIELDS)
                                               | {20'd0, LEN_DONE_BEATS, 3'd0};
                            dma_on = 1'b0;
                            exp.beat_last = 1'b1;
                            n_transfers++;
                        end
                        n_beats++;
                    end
                end
            endcase
            exp.halted = halted;
            if (exp.irq_raise) n_irq++;
            expected_q.push_back(exp);
        endfunction

        function void check_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                errors++;
            end
        endfunction

        // compare one result beat with the oldest pending one
        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            n_results++;
            check_field("read_data", exp.read_data, got.read_data);
            check_field("beat_valid", exp.beat_valid, got.beat_valid);
            check_field("beat_to_main", exp.beat_to_main, got.beat_to_main);
            check_field("beat_instr_mem", exp.beat_instr_mem, got.beat_instr_mem);
            check_field("beat_local_index", exp.beat_local_index, got.beat_local_index);
            check_field("beat_main_word", exp.beat_main_word, got.beat_main_word);
            check_field("beat_last", exp.beat_last, got.beat_last);
            check_field("irq_raise", exp.irq_raise, got.irq_raise);
            check_field("irq_clear", exp.irq_clear, got.irq_clear);
            check_field("pc_write_valid", exp.pc_write_valid, got.pc_write_valid);
            check_field("pc_value", exp.pc_value, got.pc_value);
            check_field("halted", exp.halted, got.halted);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [3:0]  s_reg_index = '0;
    logic [31:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_beat_valid;
    logic        m_beat_to_main;
    logic        m_beat_instr_mem;
    logic [8:0]  m_beat_local_index;
    logic [20:0] m_beat_main_word;
    logic        m_beat_last;
    logic        m_irq_raise;
    logic        m_irq_clear;
    logic        m_pc_write_valid;
    logic [31:0] m_pc_value;
    logic        m_halted;

    dma_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;
    int n_big = 0;

    coprocessor_interface_strided_dma_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_reg_index        (s_reg_index),
        .s_write_data       (s_write_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_beat_valid       (m_beat_valid),
        .m_beat_to_main     (m_beat_to_main),
        .m_beat_instr_mem   (m_beat_instr_mem),
        .m_beat_local_index (m_beat_local_index),
        .m_beat_main_word   (m_beat_main_word),
        .m_beat_last        (m_beat_last),
        .m_irq_raise        (m_irq_raise),
        .m_irq_clear        (m_irq_clear),
        .m_pc_write_valid   (m_pc_write_valid),
        .m_pc_value         (m_pc_value),
        .m_halted           (m_halted)
    );

    always #1 aclk = ~aclk;

    // offer one beat, with a random gap whenever a burst runs out
    task automatic send_item(input op_t op, input logic [3:0] idx, input logic [31:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_reg_index  <= idx;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, idx, data);
        items_sent++;
        burst_left--;
    endtask

    function automatic logic [31:0] status_cmd(logic [1:0] halt_sel, logic brk_clr,
                                               logic [1:0] irq_sel, logic [1:0] ss_sel,
                                               logic [1:0] iob_sel, logic [1:0] sig_sel);
        return {7'd0, {8{sig_sel}}, iob_sel, ss_sel, irq_sel, brk_clr, halt_sel};
    endfunction

    // length word with random bits in the places the mask drops
    function automatic logic [31:0] len_cmd(logic [8:0] beats, logic [7:0] rows,
                                            logic [8:0] skip);
        logic [31:0] junk;
        junk = $urandom;
        return {skip, junk[22:20], rows, beats, junk[2:0]};
    endfunction

    // any item at all; a length write that would start a transfer stays short
    task automatic send_noise();
        op_t         op;
        logic [3:0]  idx;
        logic [31:0] data;
        op   = op_t'($urandom_range(0, 3));
        idx  = 4'($urandom_range(0, 15));
        data = $urandom;
        if (op == OP_WRITE && (idx == REG_TO_LOCAL || idx == REG_TO_MAIN) && !sb.dma_on)
            data = len_cmd(9'($urandom_range(0, 7)), 8'($urandom_range(0, 3)), data[31:23]);
        send_item(op, idx, data);
    endtask

    // set up addresses, start a transfer and tick it to the end with traffic mixed in
    task automatic run_transfer();
        logic [8:0]  beats;
        logic [7:0]  rows;
        int          pick;
        if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_LOCAL_ADDR, $urandom);
        if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_MAIN_ADDR, $urandom);
        beats = 9'($urandom_range(0, 7));
        rows  = 8'($urandom_range(0, 3));
        if (n_big == 0 && items_sent > 200) begin
            beats = 9'h1FF;
            rows  = 8'd0;
            n_big++;
        end else if (n_big == 1 && items_sent > 600) begin
            beats = 9'd0;
            rows  = 8'hFF;
            n_big++;
        end
        send_item(OP_WRITE, $urandom_range(0, 1) ? REG_TO_MAIN : REG_TO_LOCAL,
                  len_cmd(beats, rows, 9'($urandom_range(0, 511))));
        while (sb.dma_on) begin
            pick = $urandom_range(0, 11);
            if (pick < 8) send_item(OP_TICK, 4'($urandom_range(0, 15)), $urandom);
            else if (pick == 8) send_item(OP_READ, 4'($urandom_range(0, 15)), $urandom);
            else if (pick == 9) send_item(OP_WRITE, 4'($urandom_range(0, 15)), $urandom);
            else if (pick == 10) send_item(OP_BREAK, 4'($urandom_range(0, 15)), $urandom);
            else send_noise();
        end
    endtask

    // result side: check every accepted beat
    always @(posedge aclk) begin : monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = result_t'({m_read_data, m_beat_valid, m_beat_to_main, m_beat_instr_mem,
                             m_beat_local_index, m_beat_main_word, m_beat_last,
                             m_irq_raise, m_irq_clear, m_pc_write_valid, m_pc_value,
                             m_halted});
            sb.check_result(got);
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial begin : receiver
        int mode;
        int span;
        bit long_done;
        long_done = 1'b0;
        wait (aresetn);
        forever begin
            if (!long_done && items_sent > 300) begin
                long_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values, unknown registers and an idle tick
        send_item(OP_READ, REG_STATUS, '0);
        send_item(OP_READ, REG_DMA_FULL, '0);
        send_item(OP_READ, 4'hF, '0);
        send_item(OP_WRITE, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_TICK, REG_LOCAL_ADDR, '0);

        // status set/clear pairs, break with and without interrupt
        send_item(OP_WRITE, REG_STATUS,
                  status_cmd(PAIR_SET, 1'b1, PAIR_SET, PAIR_SET, PAIR_SET, PAIR_SET));
        send_item(OP_READ, REG_STATUS, '0);
        send_item(OP_BREAK, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_READ, REG_STATUS, '0);
        send_item(OP_WRITE, REG_STATUS,
                  status_cmd(PAIR_CLEAR, 1'b0, PAIR_CLEAR, PAIR_CLEAR, PAIR_CLEAR,
                             PAIR_CLEAR));
        send_item(OP_BREAK, REG_STATUS, '0);
        send_item(OP_WRITE, REG_STATUS, 32'hFFFF_FFFF);

        // semaphore read-then-set, PC forward
        send_item(OP_READ, REG_SEMAPHORE, '0);
        send_item(OP_READ, REG_SEMAPHORE, '0);
        send_item(OP_WRITE, REG_SEMAPHORE, '0);
        send_item(OP_WRITE, REG_PC, 32'hFFFF_FFFF);

        // two-row transfer wrapping both addresses, with maximum skip
        send_item(OP_WRITE, REG_LOCAL_ADDR, 32'hFFFF_FFFF);
        send_item(OP_WRITE, REG_MAIN_ADDR, 32'hFFFF_FFFF);
        send_item(OP_READ, REG_MAIN_ADDR, '0);
        send_item(OP_WRITE, REG_TO_MAIN, len_cmd(9'd0, 8'd1, 9'h1FF));
        send_item(OP_WRITE, REG_TO_LOCAL, 32'hFFFF_FFFF);
        send_item(OP_READ, REG_DMA_BUSY, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_READ, REG_TO_MAIN, '0);

        // random part: mostly complete transfers, the rest loose traffic
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) run_transfer();
            else repeat ($urandom_range(1, 8)) send_noise();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d items, %0d results, %0d dma beats in %0d transfers",
                 items_sent, sb.n_results, sb.n_beats, sb.n_transfers);
        $display("%0d interrupt raises, %0d mismatches", sb.n_irq, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cidma_pkg.sv
rtl/core/cidma_in_stage.sv
rtl/core/cidma_engine.sv
rtl/core/cidma_out_stage.sv
rtl/core/coprocessor_interface_strided_dma_core.sv
rtl/core/cidma_checker.sv
test/tb.sv
